>>> sv/sbfs_pkg.sv
package sbfs_pkg;

   // Search limits and number formats.
   localparam int COUNT_WIDTH = 16;
   localparam int MAX_STEPS   = 256;
   localparam int FRAC_BITS   = 16;

   localparam int VALUE_W  = 32;
   localparam int TOL_W    = 16;
   localparam int TOL_FRAC = 16;
   localparam int FIELD_W  = 16;
   localparam int STEP_W   = $clog2(MAX_STEPS + 1);

   // The magnitude and both target terms A/B.
   localparam int MAG_W  = VALUE_W;
   localparam int COEF_W = FRAC_BITS + 1;

   // Running products of the bounds with A, B and tolerance*B.
   localparam int AP_W = COEF_W + COUNT_WIDTH;
   localparam int BP_W = MAG_W + COUNT_WIDTH;
   localparam int TB_W = TOL_W + MAG_W;
   localparam int TP_W = TB_W + COUNT_WIDTH;
   localparam int AQ_W = AP_W + 1;
   localparam int PB_W = BP_W + 1;
   localparam int TQ_W = TP_W + 1;
   localparam int D_W  = (AQ_W > PB_W) ? AQ_W : PB_W;
   localparam int CMP_W = (D_W + TOL_FRAC > TQ_W) ? D_W + TOL_FRAC : TQ_W;

   typedef logic [VALUE_W-1:0]     value_type;
   typedef logic [TOL_W-1:0]       tol_type;
   typedef logic [FIELD_W-1:0]     field_type;
   typedef logic [STEP_W-1:0]      step_type;
   typedef logic [MAG_W-1:0]       mag_type;
   typedef logic [COEF_W-1:0]      coef_type;
   typedef logic [COUNT_WIDTH-1:0] term_type;
   typedef logic [COUNT_WIDTH:0]   term_sum_type;
   typedef logic [AP_W-1:0]        aprod_type;
   typedef logic [BP_W-1:0]        bprod_type;
   typedef logic [TB_W-1:0]        tb_type;
   typedef logic [TP_W-1:0]        tprod_type;
   typedef logic [AQ_W-1:0]        asum_type;
   typedef logic [PB_W-1:0]        bsum_type;
   typedef logic [TQ_W-1:0]        tsum_type;
   typedef logic [D_W-1:0]         diff_type;
   typedef logic [CMP_W-1:0]       cmp_type;

   localparam mag_type ONE_VAL    = mag_type'(1) << FRAC_BITS;
   localparam tol_type TOL_RESET  = tol_type'(66);
   localparam step_type STEP_LIMIT = step_type'(MAX_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCALE,
      ST_SUM,
      ST_TEST,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic scale;
      logic sum;
      logic test;
   } dp_ctrl_type;

   typedef struct packed {
      logic overflow;
      logic in_tol;
   } dp_status_type;

endpackage

>>> sv/stern_brocot_fraction_search.sv
// Finds a fraction close to a signed Q16.16 value by Stern-Brocot mediant search.
// Input channel: req_valid / req_stall with req_value. The block takes one item
// at a time and holds req_stall high from the cycle after acceptance until the
// result has been handed to the output register.
// Result channel: rsp_valid / rsp_stall with rsp_negative, rsp_numerator,
// rsp_denominator and rsp_found. When no mediant meets the tolerance within
// 256 steps, or a term would exceed 16 bits, rsp_found is low and the fraction
// reads 0/1.
// Each step has two states: ST_SUM forms the mediant and its running products,
// and ST_TEST does the subtract and compare that decides the step. The next
// item is taken the cycle after the result is loaded at the earliest.
// A stalled result waits in the output register while the next item is
// accepted and searched; a finished search waits until the register is free.
// csr_wr_en writes the tolerance (unsigned Q0.16) from csr_wr_data; the user must
// write it only while the block is idle, as the block itself does not enforce this.
// Reset is synchronous: the block returns to idle, the output register empties
// and the tolerance returns to 66.
module stern_brocot_fraction_search (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sbfs_pkg::value_type  req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_negative,
   output sbfs_pkg::field_type  rsp_numerator,
   output sbfs_pkg::field_type  rsp_denominator,
   output logic                 rsp_found,
   input  logic                 csr_wr_en,
   input  sbfs_pkg::tol_type    csr_wr_data
);

   sbfs_pkg::tol_type       tolerance_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_negative_ff;
   sbfs_pkg::field_type     rsp_numerator_ff, rsp_denominator_ff;
   logic                    rsp_found_ff;

   sbfs_pkg::dp_ctrl_type   dp_ctrl;
   sbfs_pkg::dp_status_type dp_status;
   logic                    out_free;
   logic                    emit;
   logic                    found;
   logic                    dp_negative;
   sbfs_pkg::field_type     dp_numerator, dp_denominator;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   sbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .out_free  (out_free),
      .dp_ctrl   (dp_ctrl),
      .emit      (emit),
      .found     (found)
   );

   sbfs_datapath u_datapath (
      .clock       (clock),
      .dp_ctrl     (dp_ctrl),
      .value       (req_value),
      .tolerance   (tolerance_ff),
      .dp_status   (dp_status),
      .negative    (dp_negative),
      .numerator   (dp_numerator),
      .denominator (dp_denominator)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= sbfs_pkg::TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tolerance_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_negative_ff    <= dp_negative;
         rsp_found_ff       <= found;
         rsp_numerator_ff   <= found ? dp_numerator : sbfs_pkg::field_type'(0);
         rsp_denominator_ff <= found ? dp_denominator : sbfs_pkg::field_type'(1);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_negative    = rsp_negative_ff;
   assign rsp_numerator   = rsp_numerator_ff;
   assign rsp_denominator = rsp_denominator_ff;
   assign rsp_found       = rsp_found_ff;

   // An accepted item keeps the input side busy while it is searched.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted again directly after an item");

   // A failed search always reports the fraction 0/1.
   a_no_match_fraction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_numerator == 0 && rsp_denominator == 1)
      else $error("no-match result carries a fraction other than 0/1");

   // A found fraction never has a zero denominator.
   a_found_denominator: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_denominator != 0)
      else $error("found fraction has a zero denominator");

   // A new result appears only at the end of a search, while the input is busy.
   a_result_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a search in progress");

endmodule

>>> sv/sbfs_datapath.sv
module sbfs_datapath (
   input  logic                     clock,
   input  sbfs_pkg::dp_ctrl_type    dp_ctrl,
   input  sbfs_pkg::value_type      value,
   input  sbfs_pkg::tol_type        tolerance,
   output sbfs_pkg::dp_status_type  dp_status,
   output logic                     negative,
   output sbfs_pkg::field_type      numerator,
   output sbfs_pkg::field_type      denominator
);

   sbfs_pkg::value_type  value_ff;
   logic                 neg_ff;
   logic                 recip_ff;
   sbfs_pkg::coef_type   a_ff;
   sbfs_pkg::mag_type    b_ff;

   sbfs_pkg::term_type   lo_num_ff, lo_den_ff, hi_num_ff, hi_den_ff;
   sbfs_pkg::aprod_type  lo_a_ff, hi_a_ff;
   sbfs_pkg::bprod_type  lo_b_ff, hi_b_ff;
   sbfs_pkg::tprod_type  lo_t_ff, hi_t_ff;

   sbfs_pkg::term_type   med_num_ff, med_den_ff;
   sbfs_pkg::asum_type   aq_ff;
   sbfs_pkg::bsum_type   pb_ff;
   sbfs_pkg::tsum_type   tq_ff;

   sbfs_pkg::mag_type      mag;
   logic                   recip;
   sbfs_pkg::tb_type       tb;
   sbfs_pkg::term_sum_type num_sum, den_sum;
   sbfs_pkg::asum_type     aq_sum;
   sbfs_pkg::bsum_type     pb_sum;
   sbfs_pkg::tsum_type     tq_sum;
   sbfs_pkg::diff_type     aq_x, pb_x, diff;
   logic                   go_low;
   sbfs_pkg::cmp_type      lhs, rhs;

   always_comb begin
      mag   = value_ff[sbfs_pkg::VALUE_W-1] ? (sbfs_pkg::mag_type'(0) - value_ff) : value_ff;
      recip = mag > sbfs_pkg::ONE_VAL;
      tb    = sbfs_pkg::tb_type'(tolerance) * sbfs_pkg::tb_type'(b_ff);

      // The mediant and its products are sums of the bound terms, so no
      // multiply is needed inside the search loop.
      num_sum = {1'b0, lo_num_ff} + {1'b0, hi_num_ff};
      den_sum = {1'b0, lo_den_ff} + {1'b0, hi_den_ff};
      aq_sum  = {1'b0, lo_a_ff} + {1'b0, hi_a_ff};
      pb_sum  = {1'b0, lo_b_ff} + {1'b0, hi_b_ff};
      tq_sum  = {1'b0, lo_t_ff} + {1'b0, hi_t_ff};

      aq_x   = sbfs_pkg::diff_type'(aq_ff);
      pb_x   = sbfs_pkg::diff_type'(pb_ff);
      go_low = aq_x > pb_x;
      diff   = go_low ? (aq_x - pb_x) : (pb_x - aq_x);
      lhs    = sbfs_pkg::cmp_type'(diff) << sbfs_pkg::TOL_FRAC;
      rhs    = sbfs_pkg::cmp_type'(tq_ff);

      dp_status.overflow = num_sum[sbfs_pkg::COUNT_WIDTH] | den_sum[sbfs_pkg::COUNT_WIDTH];
      dp_status.in_tol   = lhs <= rhs;
   end

   always_ff @(posedge clock) begin
      if (dp_ctrl.load) begin
         value_ff <= value;
      end
      if (dp_ctrl.prep) begin
         neg_ff   <= value_ff[sbfs_pkg::VALUE_W-1];
         recip_ff <= recip;
         a_ff     <= recip ? sbfs_pkg::coef_type'(sbfs_pkg::ONE_VAL)
                           : sbfs_pkg::coef_type'(mag);
         b_ff     <= recip ? mag : sbfs_pkg::ONE_VAL;
      end
      if (dp_ctrl.scale) begin
         lo_num_ff <= sbfs_pkg::term_type'(0);
         lo_den_ff <= sbfs_pkg::term_type'(1);
         hi_num_ff <= sbfs_pkg::term_type'(1);
         hi_den_ff <= sbfs_pkg::term_type'(1);
         lo_a_ff   <= sbfs_pkg::aprod_type'(a_ff);
         hi_a_ff   <= sbfs_pkg::aprod_type'(a_ff);
         lo_b_ff   <= '0;
         hi_b_ff   <= sbfs_pkg::bprod_type'(b_ff);
         lo_t_ff   <= sbfs_pkg::tprod_type'(tb);
         hi_t_ff   <= sbfs_pkg::tprod_type'(tb);
      end
      if (dp_ctrl.sum) begin
         med_num_ff <= num_sum[sbfs_pkg::COUNT_WIDTH-1:0];
         med_den_ff <= den_sum[sbfs_pkg::COUNT_WIDTH-1:0];
         aq_ff      <= aq_sum;
         pb_ff      <= pb_sum;
         tq_ff      <= tq_sum;
      end
      // Terms are in range here, so the sums fit back into the bound widths.
      if (dp_ctrl.test && !dp_status.in_tol) begin
         if (go_low) begin
            lo_num_ff <= med_num_ff;
            lo_den_ff <= med_den_ff;
            lo_a_ff   <= aq_ff[sbfs_pkg::AP_W-1:0];
            lo_b_ff   <= pb_ff[sbfs_pkg::BP_W-1:0];
            lo_t_ff   <= tq_ff[sbfs_pkg::TP_W-1:0];
         end else begin
            hi_num_ff <= med_num_ff;
            hi_den_ff <= med_den_ff;
            hi_a_ff   <= aq_ff[sbfs_pkg::AP_W-1:0];
            hi_b_ff   <= pb_ff[sbfs_pkg::BP_W-1:0];
            hi_t_ff   <= tq_ff[sbfs_pkg::TP_W-1:0];
         end
      end
   end

   assign negative    = neg_ff;
   assign numerator   = recip_ff ? sbfs_pkg::field_type'(med_den_ff)
                                 : sbfs_pkg::field_type'(med_num_ff);
   assign denominator = recip_ff ? sbfs_pkg::field_type'(med_num_ff)
                                 : sbfs_pkg::field_type'(med_den_ff);

endmodule

>>> sv/sbfs_ctrl.sv
module sbfs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  sbfs_pkg::dp_status_type  dp_status,
   input  logic                     out_free,
   output sbfs_pkg::dp_ctrl_type    dp_ctrl,
   output logic                     emit,
   output logic                     found
);

   sbfs_pkg::state_type state_ff, state_in;
   sbfs_pkg::step_type  step_ff, step_in;
   logic                found_ff, found_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      found_ff <= found_in;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      found_in = found_ff;
      dp_ctrl  = '0;
      emit     = 1'b0;
      case (state_ff)
         sbfs_pkg::ST_IDLE: begin
            if (req_valid) begin
               dp_ctrl.load = 1'b1;
               state_in     = sbfs_pkg::ST_PREP;
            end
         end
         sbfs_pkg::ST_PREP: begin
            dp_ctrl.prep = 1'b1;
            state_in     = sbfs_pkg::ST_SCALE;
         end
         sbfs_pkg::ST_SCALE: begin
            dp_ctrl.scale = 1'b1;
            step_in       = '0;
            state_in      = sbfs_pkg::ST_SUM;
         end
         sbfs_pkg::ST_SUM: begin
            if (step_ff == sbfs_pkg::STEP_LIMIT || dp_status.overflow) begin
               found_in = 1'b0;
               state_in = sbfs_pkg::ST_DONE;
            end else begin
               dp_ctrl.sum = 1'b1;
               step_in     = step_ff + sbfs_pkg::step_type'(1);
               state_in    = sbfs_pkg::ST_TEST;
            end
         end
         sbfs_pkg::ST_TEST: begin
            dp_ctrl.test = 1'b1;
            if (dp_status.in_tol) begin
               found_in = 1'b1;
               state_in = sbfs_pkg::ST_DONE;
            end else begin
               state_in = sbfs_pkg::ST_SUM;
            end
         end
         sbfs_pkg::ST_DONE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = sbfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbfs_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != sbfs_pkg::ST_IDLE);
   assign found     = found_ff;

endmodule
